/* rtl/cet2o_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cet2o_pkg;

	localparam int FRAC_BITS_DEF   = 24;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int A_W        = 27;
	localparam int C_W        = 28;
	localparam int Z_W        = 32;
	localparam int ITER_W     = 16;
	localparam int CODE_W     = 9;
	localparam int MOD_W      = 4;
	localparam int SAT_W      = 66;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	localparam int MOD_BASE       = 15;
	localparam int ESCAPE_RAD_SQ  = 10;
	localparam int ITER_RESET     = 100;

	localparam logic [CFG_IDX_W-1:0] REG_A_RE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_IM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

	localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};

	typedef struct packed {
		logic signed [A_W-1:0] a_re;
		logic signed [A_W-1:0] a_im;
		logic [ITER_W-1:0]     max_iter;
	} cfg_t;

	typedef struct packed {
		logic signed [C_W-1:0] c_re;
		logic signed [C_W-1:0] c_im;
		logic signed [Z_W-1:0] k_re;
		logic signed [Z_W-1:0] k_im;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic signed [Z_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
		logic signed [Z_W-1:0] r;
		if (x > SAT_HI) begin
			r = {1'b0, {(Z_W-1){1'b1}}};
		end else if (x < SAT_LO) begin
			r = {1'b1, {(Z_W-1){1'b0}}};
		end else begin
			r = x[Z_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/cet2o_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cet2o_queue #(
	parameter int DEPTH = cet2o_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  cet2o_pkg::job_t       wr_job,
	input  wire                   pop,
	output cet2o_pkg::job_t       rd_job,
	output cet2o_pkg::q_status_t  status
);
	import cet2o_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_job       = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

endmodule

`default_nettype wire

/* rtl/cet2o_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cet2o_front #(
	parameter int FRAC_BITS = cet2o_pkg::FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [cet2o_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cet2o_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  signed [cet2o_pkg::C_W-1:0]      in_re,
	input  wire  signed [cet2o_pkg::C_W-1:0]      in_im,
	output cet2o_pkg::cfg_t                       cfg,
	input  cet2o_pkg::q_status_t                  q_status,
	output logic                                  push,
	output cet2o_pkg::job_t                       job
);
	import cet2o_pkg::*;

	localparam int P_W = 2 * A_W;
	localparam int K_W = P_W + 4;

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic signed [C_W-1:0] c_re_s1;
	logic signed [C_W-1:0] c_im_s1;
	logic signed [P_W-1:0] p_rr_s1;
	logic signed [P_W-1:0] p_ii_s1;
	logic signed [P_W-1:0] p_ri_s1;
	logic signed [K_W-1:0] diff;
	logic signed [K_W-1:0] prod;
	logic signed [K_W-1:0] k_re_full;
	logic signed [K_W-1:0] k_im_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_re     <= '0;
			cfg_q.a_im     <= '0;
			cfg_q.max_iter <= ITER_W'(ITER_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_A_RE:     cfg_q.a_re     <= cfg_data[A_W-1:0];
				REG_A_IM:     cfg_q.a_im     <= cfg_data[A_W-1:0];
				REG_MAX_ITER: cfg_q.max_iter <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg      = cfg_q;
	assign push     = valid_s1 && !q_status.full;
	assign in_ready = !valid_s1 || !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_re_s1 <= in_re;
			c_im_s1 <= in_im;
			p_rr_s1 <= cfg_q.a_re * cfg_q.a_re;
			p_ii_s1 <= cfg_q.a_im * cfg_q.a_im;
			p_ri_s1 <= cfg_q.a_re * cfg_q.a_im;
		end
	end

	// 3*a^2 = 3*(re^2 - im^2) + j*6*re*im, floored back to Q.F
	always_comb begin
		diff      = K_W'(p_rr_s1) - K_W'(p_ii_s1);
		prod      = K_W'(p_ri_s1);
		k_re_full = (diff + (diff <<< 1)) >>> FRAC_BITS;
		k_im_full = ((prod <<< 2) + (prod <<< 1)) >>> FRAC_BITS;
	end

	assign job.c_re = c_re_s1;
	assign job.c_im = c_im_s1;
	assign job.k_re = sat32(SAT_W'(k_re_full));
	assign job.k_im = sat32(SAT_W'(k_im_full));

endmodule

`default_nettype wire

/* rtl/cet2o_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cet2o_back #(
	parameter int FRAC_BITS  = cet2o_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = cet2o_pkg::COUNT_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  cet2o_pkg::cfg_t                    cfg,
	input  cet2o_pkg::q_status_t               q_status,
	input  cet2o_pkg::job_t                    job,
	output logic                               pop,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [cet2o_pkg::CODE_W-1:0]       out_code
);
	import cet2o_pkg::*;

	localparam int PW = 2 * Z_W;
	localparam int SW = PW + 1;
	localparam logic [SW-1:0] ESC_LIM = SW'(ESCAPE_RAD_SQ) << (2 * FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_EVAL,
		ST_MUL2,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic signed [C_W-1:0]  c_re_q;
	logic signed [C_W-1:0]  c_im_q;
	logic signed [Z_W-1:0]  k_re_q;
	logic signed [Z_W-1:0]  k_im_q;
	logic signed [Z_W-1:0]  z_re_q;
	logic signed [Z_W-1:0]  z_im_q;
	logic signed [Z_W-1:0]  t1_q;
	logic signed [Z_W-1:0]  t2_q;
	logic signed [PW-1:0]   p_rr_q;
	logic signed [PW-1:0]   p_ii_q;
	logic signed [PW-1:0]   p_ri_q;
	logic signed [PW-1:0]   m_a_q;
	logic signed [PW-1:0]   m_b_q;
	logic signed [PW-1:0]   m_c_q;
	logic signed [PW-1:0]   m_d_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [MOD_W-1:0]       mod_q;
	logic                   phase_q;
	logic [MOD_W-1:0]       i_mod_q;
	logic                   i_bnd_q;
	logic [MOD_W-1:0]       j_mod_q;
	logic                   j_bnd_q;
	logic                   out_valid_q;
	logic [CODE_W-1:0]      out_code_q;

	logic [COUNT_BITS-1:0]  lim;
	logic signed [Z_W-1:0]  a_re_ext;
	logic signed [Z_W-1:0]  a_im_ext;
	logic [SW-1:0]          mag;
	logic                   bounded;
	logic                   escaped;
	logic signed [SW-1:0]   sq_diff;
	logic signed [SW-1:0]   sum_re;
	logic signed [SW-1:0]   sum_im;
	logic signed [Z_W-1:0]  t1_d;
	logic signed [Z_W-1:0]  t2_d;
	logic signed [Z_W-1:0]  z_re_d;
	logic signed [Z_W-1:0]  z_im_d;
	logic [MOD_W-1:0]       i_inc;
	logic [MOD_W-1:0]       j_inc;
	logic [CODE_W-1:0]      code_d;

	always_comb begin
		lim      = COUNT_BITS'(cfg.max_iter);
		a_re_ext = Z_W'(cfg.a_re);
		a_im_ext = Z_W'(cfg.a_im);
		mag      = $unsigned(SW'(p_rr_q)) + $unsigned(SW'(p_ii_q));
		bounded  = (cnt_q >= lim);
		escaped  = (mag >= ESC_LIM);
		sq_diff  = (SW'(p_rr_q) - SW'(p_ii_q)) >>> FRAC_BITS;
		t1_d     = sat32(SAT_W'(sq_diff) - SAT_W'(k_re_q));
		t2_d     = sat32(SAT_W'(p_ri_q >>> (FRAC_BITS - 1)) - SAT_W'(k_im_q));
		sum_re   = (SW'(m_a_q) - SW'(m_b_q)) >>> FRAC_BITS;
		sum_im   = (SW'(m_c_q) + SW'(m_d_q)) >>> FRAC_BITS;
		z_re_d   = sat32(SAT_W'(sum_re) + SAT_W'(c_re_q));
		z_im_d   = sat32(SAT_W'(sum_im) + SAT_W'(c_im_q));
		i_inc    = i_mod_q + 1'b1;
		j_inc    = j_mod_q + 1'b1;
		if (i_bnd_q && j_bnd_q) begin
			code_d = '1;
		end else if (i_bnd_q) begin
			code_d = CODE_W'(j_inc);
		end else if (j_bnd_q) begin
			code_d = {1'b0, i_inc, {MOD_W{1'b0}}};
		end else begin
			code_d = {1'b0, i_inc, j_inc};
		end
	end

	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			c_re_q      <= '0;
			c_im_q      <= '0;
			k_re_q      <= '0;
			k_im_q      <= '0;
			z_re_q      <= '0;
			z_im_q      <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			p_rr_q      <= '0;
			p_ii_q      <= '0;
			p_ri_q      <= '0;
			m_a_q       <= '0;
			m_b_q       <= '0;
			m_c_q       <= '0;
			m_d_q       <= '0;
			cnt_q       <= '0;
			mod_q       <= '0;
			phase_q     <= 1'b0;
			i_mod_q     <= '0;
			i_bnd_q     <= 1'b0;
			j_mod_q     <= '0;
			j_bnd_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						c_re_q  <= job.c_re;
						c_im_q  <= job.c_im;
						k_re_q  <= job.k_re;
						k_im_q  <= job.k_im;
						z_re_q  <= a_re_ext;
						z_im_q  <= a_im_ext;
						cnt_q   <= '0;
						mod_q   <= '0;
						phase_q <= 1'b0;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					p_rr_q  <= z_re_q * z_re_q;
					p_ii_q  <= z_im_q * z_im_q;
					p_ri_q  <= z_re_q * z_im_q;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (bounded || escaped) begin
						if (!phase_q) begin
							i_mod_q <= mod_q;
							i_bnd_q <= bounded;
							z_re_q  <= -a_re_ext;
							z_im_q  <= -a_im_ext;
							cnt_q   <= '0;
							mod_q   <= '0;
							phase_q <= 1'b1;
							state_q <= ST_MUL1;
						end else begin
							j_mod_q <= mod_q;
							j_bnd_q <= bounded;
							state_q <= ST_DONE;
						end
					end else begin
						t1_q    <= t1_d;
						t2_q    <= t2_d;
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					m_a_q   <= t1_q * z_re_q;
					m_b_q   <= t2_q * z_im_q;
					m_c_q   <= t1_q * z_im_q;
					m_d_q   <= t2_q * z_re_q;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					z_re_q  <= z_re_d;
					z_im_q  <= z_im_d;
					cnt_q   <= cnt_q + 1'b1;
					mod_q   <= (mod_q == MOD_W'(MOD_BASE - 1)) ? '0 : mod_q + 1'b1;
					state_q <= ST_MUL1;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_code_q  <= code_d;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/cubic_escape_time_two_orbits_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cubic escape-time colour unit: for each point c it runs the orbit of
// z -> z^3 - 3a^2 z + c from z = +a and from z = -a, in signed Q8.24, and
// returns a 9-bit colour code (-1 when both orbits stay bounded). The front
// takes one point per cycle while its queue has room and works out 3a^2;
// the back runs the iterations through one shared step unit, passing through
// ST_MUL1, ST_EVAL, ST_MUL2 and ST_UPD for each iteration (two multiply
// rounds), plus ST_MUL1 and ST_EVAL for the final escape test of each orbit.
// Each point occupies the back until both its orbits end; the limit resets to 100.
// The result register lets the back start the next point while a code waits.
// Registers may be written only while the unit holds no point in flight.

module cubic_escape_time_two_orbits_unit #(
	parameter int FRAC_BITS   = cet2o_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS  = cet2o_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = cet2o_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_valid,
	output logic                                     cfg_ready,
	input  wire  [cet2o_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [cet2o_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire                                      s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire  [cet2o_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // pixel_re, pixel_im
	output logic                                     m_axis_tvalid,
	input  wire                                      m_axis_tready,
	output logic [cet2o_pkg::OUT_TDATA_W-1:0]        m_axis_tdata   // color_code, zero fill
);
	import cet2o_pkg::*;

	cfg_t              cfg;
	job_t              wr_job;
	job_t              rd_job;
	q_status_t         q_status;
	logic              q_push;
	logic              q_pop;
	logic [CODE_W-1:0] color_code;

	cet2o_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_re     (s_axis_tdata[C_W-1:0]),
		.in_im     (s_axis_tdata[2*C_W-1:C_W]),
		.cfg       (cfg),
		.q_status  (q_status),
		.push      (q_push),
		.job       (wr_job)
	);

	cet2o_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.pop    (q_pop),
		.rd_job (rd_job),
		.status (q_status)
	);

	cet2o_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_status  (q_status),
		.job       (rd_job),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_code  (color_code)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-CODE_W){1'b0}}, color_code};

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue read while empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_status.empty)
		else $error("queue empty after a lone write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled transaction dropped or changed");

endmodule

`default_nettype wire

/* tb/cubic_escape_time_two_orbits_unit_tb.sv */
`timescale 1ns / 1ps

module cubic_escape_time_two_orbits_unit_tb;
	import cet2o_pkg::*;

	localparam int F = FRAC_BITS_DEF;
	localparam int Q = 1 << F;
	localparam int LIMIT_CYCLES = 8000000;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [SAT_W-1:0] ESCAPE_SQ = ESCAPE_RAD_SQ * (66'sd1 <<< (2 * F));
	localparam logic signed [SAT_W-1:0] Z_TOP = (66'sd1 <<< (Z_W - 1)) - 66'sd1;
	localparam logic signed [SAT_W-1:0] Z_BOT = -(66'sd1 <<< (Z_W - 1));
	localparam logic signed [C_W-1:0] C_TOP = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_BOT = {1'b1, {(C_W-1){1'b0}}};
	localparam logic signed [A_W-1:0] A_TOP = {1'b0, {(A_W-1){1'b1}}};
	localparam logic signed [A_W-1:0] A_BOT = {1'b1, {(A_W-1){1'b0}}};

	class colour_scoreboard;
		logic signed [A_W-1:0] a_re;
		logic signed [A_W-1:0] a_im;
		logic [ITER_W-1:0] max_iter;
		logic signed [Z_W-1:0] k_re;
		logic signed [Z_W-1:0] k_im;
		logic signed [CODE_W-1:0] pending[$];
		int errors;
		int accepted;
		int checked;

		function new();
			a_re = '0;
			a_im = '0;
			max_iter = ITER_W'(ITER_RESET);
			k_re = '0;
			k_im = '0;
			errors = 0;
			accepted = 0;
			checked = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_A_RE: a_re = data;
				REG_A_IM: a_im = data;
				REG_MAX_ITER: max_iter = data[ITER_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [Z_W-1:0] clamp32(logic signed [SAT_W-1:0] x);
			if (x > Z_TOP)
				return Z_TOP[Z_W-1:0];
			if (x < Z_BOT)
				return Z_BOT[Z_W-1:0];
			return x[Z_W-1:0];
		endfunction

		function int orbit_length(logic signed [SAT_W-1:0] zr, logic signed [SAT_W-1:0] zi,
				logic signed [C_W-1:0] c_re, logic signed [C_W-1:0] c_im);
			logic signed [SAT_W-1:0] re, im, nr, ni, t1, t2, cr, ci, kr, ki;
			int n;
			re = zr;
			im = zi;
			cr = SAT_W'(c_re);
			ci = SAT_W'(c_im);
			kr = SAT_W'(k_re);
			ki = SAT_W'(k_im);
			n = 0;
			while (n < int'(max_iter) && (re * re + im * im) < ESCAPE_SQ) begin
				t1 = SAT_W'(clamp32(((re * re - im * im) >>> F) - kr));
				t2 = SAT_W'(clamp32(((re * im) >>> (F - 1)) - ki));
				nr = SAT_W'(clamp32(((t1 * re - t2 * im) >>> F) + cr));
				ni = SAT_W'(clamp32(((t1 * im + t2 * re) >>> F) + ci));
				re = nr;
				im = ni;
				n++;
			end
			return n;
		endfunction

		function logic signed [CODE_W-1:0] colour_for(logic signed [C_W-1:0] c_re,
				logic signed [C_W-1:0] c_im);
			logic signed [SAT_W-1:0] war, wai;
			int i, j, lim, code;
			war = SAT_W'(a_re);
			wai = SAT_W'(a_im);
			lim = int'(max_iter);
			k_re = clamp32((66'sd3 * (war * war - wai * wai)) >>> F);
			k_im = clamp32((66'sd6 * war * wai) >>> F);
			i = orbit_length(war, wai, c_re, c_im);
			j = orbit_length(-war, -wai, c_re, c_im);
			if (i >= lim && j >= lim)
				code = -1;
			else if (i >= lim)
				code = (j % MOD_BASE) + 1;
			else if (j >= lim)
				code = ((i % MOD_BASE) + 1) * 16;
			else
				code = ((i % MOD_BASE) + 1) * 16 + (j % MOD_BASE) + 1;
			return CODE_W'(code);
		endfunction

		function void note_pixel(logic signed [C_W-1:0] c_re, logic signed [C_W-1:0] c_im);
			pending.push_back(colour_for(c_re, c_im));
			accepted++;
		endfunction

		task check_code(logic [OUT_TDATA_W-1:0] word);
			logic signed [CODE_W-1:0] want, got;
			got = word[CODE_W-1:0];
			if (pending.size() == 0) begin
				report($sformatf("colour code %0d with no pixel outstanding", got));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want)
				report($sformatf("colour code %0d, wanted %0d (result %0d)", got, want, checked));
			if (word[OUT_TDATA_W-1:CODE_W] !== '0)
				report($sformatf("fill bits of result %0d are %h", checked, word));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tready = 1'b0;
	wire cfg_ready;
	wire s_axis_tready;
	wire m_axis_tvalid;
	wire [OUT_TDATA_W-1:0] m_axis_tdata;

	colour_scoreboard sb;
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	int rx_wait = 0;
	int cycles = 0;
	int reg_sets = 0;

	cubic_escape_time_two_orbits_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("cubic_escape_time_two_orbits_unit_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_code(m_axis_tdata);
				rx_wait = rx_steady ? 0 : $urandom_range(0, 7);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_axis_tready <= (rx_wait == 0);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_reg(idx, data);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] ar, logic [CFG_DATA_W-1:0] ai,
			logic [CFG_DATA_W-1:0] mx, bit spare);
		write_reg(REG_A_RE, ar);
		write_reg(REG_A_IM, ai);
		write_reg(REG_MAX_ITER, mx);
		if (spare)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		reg_sets++;
	endtask

	task automatic send_pixel(logic signed [C_W-1:0] c_re, logic signed [C_W-1:0] c_im);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c_im, c_re};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(c_re, c_im);
	endtask

	// hold off until every colour code is back, so the unit is idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic int spread(int b);
		return int'($urandom_range(0, 2 * b)) - b;
	endfunction

	function automatic logic signed [C_W-1:0] draw_coord();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 65)
			return C_W'(spread(2 * Q));
		if (sel < 85)
			return C_W'($urandom);
		if (sel < 95) begin
			case ($urandom_range(0, 3))
				0: return C_TOP;
				1: return C_BOT;
				2: return '0;
				default: return '1;
			endcase
		end
		return C_W'(spread(4 * Q));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_a();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return CFG_DATA_W'(spread(Q));
		if (sel < 85)
			return CFG_DATA_W'(spread(53687091));
		return CFG_DATA_W'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_limit();
		int sel;
		logic [CFG_DATA_W-1:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			v = CFG_DATA_W'($urandom_range(1, 24));
		else if (sel < 80)
			v = CFG_DATA_W'($urandom_range(25, 100));
		else if (sel < 90)
			v = CFG_DATA_W'(1);
		else
			v = CFG_DATA_W'($urandom_range(2, 8));
		// junk above the counter width is masked off by the unit
		if ($urandom_range(0, 9) == 0)
			v[CFG_DATA_W-1:ITER_W] = (CFG_DATA_W-ITER_W)'($urandom);
		return v;
	endfunction

	initial begin
		int n, total;
		logic [CFG_DATA_W-1:0] mx;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config('0, '0, 100, 1'b1);
		send_pixel('0, '0);
		send_pixel(C_TOP, C_TOP);
		send_pixel(C_BOT, C_BOT);
		send_pixel(C_TOP, '0);
		send_pixel('0, C_BOT);
		send_pixel(C_W'(-2 * Q), '0);
		send_pixel(C_W'(Q / 4), '0);
		send_pixel('1, '1);
		drain();

		set_config(A_TOP, A_BOT, 1, 1'b0);
		send_pixel('0, '0);
		send_pixel(C_TOP, C_BOT);
		send_pixel(C_W'(5 * Q), C_W'(-3 * Q));
		drain();

		set_config(A_BOT, A_TOP, '1, 1'b0);
		send_pixel('0, '0);
		send_pixel(C_BOT, C_TOP);
		drain();

		// counter-width mask leaves a zero limit
		set_config('0, '0, 27'h0010000, 1'b0);
		send_pixel('0, '0);
		send_pixel(C_TOP, C_TOP);
		drain();

		set_config('0, '0, 27'h000FFFF, 1'b0);
		send_pixel(C_TOP, '0);
		send_pixel(C_W'(-2 * Q), '0);
		send_pixel(C_BOT, C_TOP);
		send_pixel('0, C_W'(3 * Q));
		drain();

		set_config(CFG_DATA_W'(Q / 2), CFG_DATA_W'(Q / 4), 100, 1'b0);
		send_pixel('0, '0);
		send_pixel(C_W'(Q / 8), C_W'(-Q / 8));
		send_pixel(C_W'(-Q / 2), C_W'(Q / 3));
		drain();

		total = sb.accepted + RANDOM_ITEMS;
		while (sb.accepted < total) begin
			tx_steady <= ($urandom_range(0, 3) == 0);
			rx_steady <= ($urandom_range(0, 3) == 0);
			mx = draw_limit();
			set_config(draw_a(), draw_a(), mx, ($urandom_range(0, 7) == 0));
			n = (mx[ITER_W-1:0] <= 24) ? $urandom_range(10, 40) : $urandom_range(5, 15);
			repeat (n)
				send_pixel(draw_coord(), draw_coord());
			drain();
		end

		repeat (50) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d colour codes never arrived", sb.pending.size()));
		$display("%0d pixels sent over %0d register settings, %0d colour codes checked",
			sb.accepted, reg_sets, sb.checked);
		$display("%0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("cubic_escape_time_two_orbits_unit_tb passed");
		else
			$display("cubic_escape_time_two_orbits_unit_tb failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/cet2o_pkg.sv
rtl/cet2o_queue.sv
rtl/cet2o_front.sv
rtl/cet2o_back.sv
rtl/cubic_escape_time_two_orbits_unit.sv
tb/cubic_escape_time_two_orbits_unit_tb.sv
